// ----- sv/tetp_pkg.sv -----
// tetp_pkg: shared types, constants and register codes for the tricorn escape-time pixel block
// no dependencies
package tetp_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 28;
	localparam int FX_W       = 32;
	localparam int PROD_W     = 2 * FX_W;
	localparam int STEP_W     = 31;
	localparam int SPC_W      = 4;
	localparam int COUNT_W    = 8;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int SHADE_W    = 8;

	typedef logic signed [FX_W-1:0] fx_t;

	localparam fx_t FX_MAX  = fx_t'(32'sh7FFF_FFFF);
	localparam fx_t FX_MIN  = fx_t'(32'sh8000_0000);
	localparam fx_t FX_FOUR = fx_t'(32'sh4000_0000);

	localparam logic [COUNT_W-1:0] MAX_ROUNDS = 8'd255;
	localparam logic [SHADE_W-1:0] SHADE_MAX  = 8'd255;

	localparam fx_t                X_ORIGIN_RST = fx_t'(-32'sd536870912);
	localparam fx_t                Y_ORIGIN_RST = fx_t'(-32'sd536870912);
	localparam logic [STEP_W-1:0]  X_STEP_RST   = 31'd1533916;
	localparam logic [STEP_W-1:0]  Y_STEP_RST   = 31'd1533916;
	localparam logic [SPC_W-1:0]   SPC_RST      = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_ORIGIN        = 3'd0,
		CFG_Y_ORIGIN        = 3'd1,
		CFG_X_STEP          = 3'd2,
		CFG_Y_STEP          = 3'd3,
		CFG_STEPS_PER_CHECK = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		fx_t               x_origin;
		fx_t               y_origin;
		logic [STEP_W-1:0] x_step;
		logic [STEP_W-1:0] y_step;
	} map_cfg_t;

	typedef struct packed {
		fx_t cx;
		fx_t cy;
	} point_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL,
		ST_DONE
	} core_state_t;

endpackage

// ----- sv/tricorn_escape_time_pixel_top.sv -----
// tricorn escape-time pixel: pixel beat in, one shade beat out
// the core runs one ST_MUL/ST_EVAL pass per eval; evals is one for the escaping
// round plus max(1, steps_per_check) per passing round, at most 256 * max(1, steps_per_check)
// the core works on one pixel at a time in its multiply/update loop; front and core
// overlap through a two-entry queue, so pixel beats are taken while the core is busy
// reset: arst_n clears all control state and loads the register defaults
module tricorn_escape_time_pixel_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  tetp_pkg::cfg_idx_t               cfg_index,
	input  logic [tetp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tetp_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [tetp_pkg::COORD_BITS-1:0]  pixel_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tetp_pkg::SHADE_W-1:0]     shade
);
	import tetp_pkg::*;

	map_cfg_t         map_cfg_q;
	logic [SPC_W-1:0] spc_q;

	logic   push_valid, push_ready, pop_valid, pop_ready;
	point_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cfg_q.x_origin <= X_ORIGIN_RST;
			map_cfg_q.y_origin <= Y_ORIGIN_RST;
			map_cfg_q.x_step   <= X_STEP_RST;
			map_cfg_q.y_step   <= Y_STEP_RST;
			spc_q              <= SPC_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_X_ORIGIN:        map_cfg_q.x_origin <= fx_t'(cfg_data);
				CFG_Y_ORIGIN:        map_cfg_q.y_origin <= fx_t'(cfg_data);
				CFG_X_STEP:          map_cfg_q.x_step   <= cfg_data[STEP_W-1:0];
				CFG_Y_STEP:          map_cfg_q.y_step   <= cfg_data[STEP_W-1:0];
				CFG_STEPS_PER_CHECK: spc_q              <= cfg_data[SPC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tetp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (map_cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tetp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tetp_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.steps_per_check (spc_q),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_data        (pop_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.shade           (shade)
	);

endmodule

// ----- sv/tetp_front.sv -----
// tetp_front: accepts pixel beats and maps them to the complex point c
// depends on tetp_pkg
module tetp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tetp_pkg::map_cfg_t             cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tetp_pkg::COORD_BITS-1:0] pixel_x,
	input  logic [tetp_pkg::COORD_BITS-1:0] pixel_y,
	output logic                           push_valid,
	input  logic                           push_ready,
	output tetp_pkg::point_t               push_data
);
	import tetp_pkg::*;

	localparam int MP_W  = COORD_BITS + STEP_W;
	localparam int SUM_W = MP_W + 2;

	function automatic fx_t sat_sum(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:FX_W-1] == {(SUM_W-FX_W+1){v[SUM_W-1]}}) begin
			return v[FX_W-1:0];
		end else if (v[SUM_W-1]) begin
			return FX_MIN;
		end else begin
			return FX_MAX;
		end
	endfunction

	logic              valid_s1;
	logic [MP_W-1:0]   px_prod_s1;
	logic [MP_W-1:0]   py_prod_s1;
	logic signed [SUM_W-1:0] x_sum;
	logic signed [SUM_W-1:0] y_sum;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_prod_s1 <= MP_W'(pixel_x) * MP_W'(cfg.x_step);
			py_prod_s1 <= MP_W'(pixel_y) * MP_W'(cfg.y_step);
		end
	end

	always_comb begin
		x_sum        = SUM_W'(cfg.x_origin) + $signed({2'b00, px_prod_s1});
		y_sum        = SUM_W'(cfg.y_origin) + $signed({2'b00, py_prod_s1});
		push_data.cx = sat_sum(x_sum);
		push_data.cy = sat_sum(y_sum);
	end

endmodule

// ----- sv/tetp_queue.sv -----
// tetp_queue: two-entry queue of mapped points between front and core
// depends on tetp_pkg
module tetp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tetp_pkg::point_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tetp_pkg::point_t pop_data
);
	import tetp_pkg::*;

	point_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/tetp_core.sv -----
// tetp_core: escape-time iteration z = conj(z)^2 + c with saturating fixed point
// depends on tetp_pkg; takes points from tetp_queue, holds the result register
module tetp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tetp_pkg::SPC_W-1:0]    steps_per_check,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  tetp_pkg::point_t              pop_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tetp_pkg::SHADE_W-1:0]  shade
);
	import tetp_pkg::*;

	localparam int WIDE_W = FX_W + 2;

	function automatic fx_t sat_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p >>> FRAC_BITS;
		if (s[PROD_W-1:FX_W-1] == {(PROD_W-FX_W+1){s[PROD_W-1]}}) begin
			return s[FX_W-1:0];
		end else if (s[PROD_W-1]) begin
			return FX_MIN;
		end else begin
			return FX_MAX;
		end
	endfunction

	function automatic fx_t sat_wide(input logic signed [WIDE_W-1:0] v);
		if (v[WIDE_W-1:FX_W-1] == {(WIDE_W-FX_W+1){v[WIDE_W-1]}}) begin
			return v[FX_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return FX_MIN;
		end else begin
			return FX_MAX;
		end
	endfunction

	core_state_t state_q, state_d;

	fx_t                      cx_q, cy_q, zr_q, zi_q;
	logic signed [PROD_W-1:0] prr_q, pii_q, pri_q;
	logic [SPC_W-1:0]         m_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     out_valid_q;
	logic [SHADE_W-1:0]       shade_q;

	fx_t              sq_r, sq_i, prod_ri, dbl, nr, ni;
	logic [FX_W:0]    mag;
	logic             esc;
	logic             round_end;
	logic             load, upd_z, m_inc, m_clr, cnt_inc, out_load;

	always_comb begin
		sq_r      = sat_prod(prr_q);
		sq_i      = sat_prod(pii_q);
		prod_ri   = sat_prod(pri_q);
		mag       = {1'b0, sq_r} + {1'b0, sq_i};
		esc       = (m_q == '0) && (mag > (FX_W+1)'(FX_FOUR));
		nr        = sat_wide(WIDE_W'(sq_r) - WIDE_W'(sq_i) + WIDE_W'(cx_q));
		dbl       = sat_wide(WIDE_W'(0) - (WIDE_W'(prod_ri) <<< 1));
		ni        = sat_wide(WIDE_W'(dbl) + WIDE_W'(cy_q));
		round_end = (steps_per_check == '0)
			|| (({1'b0, m_q} + (SPC_W+1)'(1)) == {1'b0, steps_per_check});
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load      = 1'b0;
		upd_z     = 1'b0;
		m_inc     = 1'b0;
		m_clr     = 1'b0;
		cnt_inc   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					load    = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (esc) begin
					state_d = ST_DONE;
				end else begin
					upd_z = (steps_per_check != '0);
					if (!round_end) begin
						m_inc   = 1'b1;
						state_d = ST_MUL;
					end else if (count_q == MAX_ROUNDS) begin
						state_d = ST_DONE;
					end else begin
						cnt_inc = 1'b1;
						m_clr   = 1'b1;
						state_d = ST_MUL;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load || m_clr) begin
				m_q <= '0;
			end else if (m_inc) begin
				m_q <= m_q + SPC_W'(1);
			end
			if (load) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q <= pop_data.cx;
			cy_q <= pop_data.cy;
			zr_q <= pop_data.cx;
			zi_q <= pop_data.cy;
		end else if (upd_z) begin
			zr_q <= nr;
			zi_q <= ni;
		end
		if (state_q == ST_MUL) begin
			prr_q <= PROD_W'(zr_q) * PROD_W'(zr_q);
			pii_q <= PROD_W'(zi_q) * PROD_W'(zi_q);
			pri_q <= PROD_W'(zr_q) * PROD_W'(zi_q);
		end
		if (out_load) begin
			shade_q <= SHADE_MAX - count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign shade     = shade_q;

endmodule

// ----- tb/tricorn_escape_time_pixel_top_tb.sv -----
// tricorn_escape_time_pixel_top_tb: self-checking bench, random pixel beats against a shade predictor
// depends on tetp_pkg and tricorn_escape_time_pixel_top
module tricorn_escape_time_pixel_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tetp_pkg::*;

	localparam int PIX_MAX = (1 << COORD_BITS) - 1;
	localparam int HOLD_CYCLES = 3000;

	class shade_scoreboard;
		fx_t x_origin;
		fx_t y_origin;
		logic [STEP_W-1:0] x_step;
		logic [STEP_W-1:0] y_step;
		logic [SPC_W-1:0] updates_per_test;
		logic [SHADE_W-1:0] pending_shades[$];
		int errors;

		function new();
			x_origin = X_ORIGIN_RST;
			y_origin = Y_ORIGIN_RST;
			x_step = X_STEP_RST;
			y_step = Y_STEP_RST;
			updates_per_test = SPC_RST;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_X_ORIGIN: x_origin = fx_t'(data);
				CFG_Y_ORIGIN: y_origin = fx_t'(data);
				CFG_X_STEP: x_step = data[STEP_W-1:0];
				CFG_Y_STEP: y_step = data[STEP_W-1:0];
				CFG_STEPS_PER_CHECK: updates_per_test = data[SPC_W-1:0];
				default: ;
			endcase
		endfunction

		function fx_t qsat(longint v);
			if (v > longint'(FX_MAX))
				return FX_MAX;
			if (v < longint'(FX_MIN))
				return FX_MIN;
			return fx_t'(v);
		endfunction

		// exact product, floor to the fraction width, then clamp
		function fx_t qmul(fx_t a, fx_t b);
			return qsat((longint'(a) * longint'(b)) >>> FRAC_BITS);
		endfunction

		function fx_t qadd(fx_t a, fx_t b);
			return qsat(longint'(a) + longint'(b));
		endfunction

		function logic [SHADE_W-1:0] escape_shade(logic [COORD_BITS-1:0] px,
				logic [COORD_BITS-1:0] py);
			fx_t cx, cy, zr, zi, nr, ni;
			int rounds;
			cx = qsat(longint'(x_origin) + longint'(px) * longint'(x_step));
			cy = qsat(longint'(y_origin) + longint'(py) * longint'(y_step));
			zr = cx;
			zi = cy;
			rounds = 0;
			while (1) begin
				if (qadd(qmul(zr, zr), qmul(zi, zi)) > FX_FOUR)
					break;
				for (int m = 0; m < updates_per_test; m++) begin
					nr = qsat(longint'(qmul(zr, zr)) - longint'(qmul(zi, zi)) + longint'(cx));
					ni = qadd(qsat(-64'sd2 * longint'(qmul(zr, zi))), cy);
					zr = nr;
					zi = ni;
				end
				if (rounds == MAX_ROUNDS)
					break;
				rounds++;
			end
			return (rounds >= int'(SHADE_MAX)) ? '0 : SHADE_W'(int'(SHADE_MAX) - rounds);
		endfunction

		function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
			pending_shades.push_back(escape_shade(px, py));
		endfunction

		function void check_shade(logic [SHADE_W-1:0] got);
			logic [SHADE_W-1:0] want;
			if (pending_shades.size() == 0) begin
				$display("%0t unexpected shade beat: expected none, actual %0d", $time, got);
				errors++;
			end else begin
				want = pending_shades.pop_front();
				if (got !== want) begin
					$display("%0t shade mismatch: expected %0d, actual %0d", $time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return pending_shades.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	cfg_idx_t cfg_index = CFG_X_ORIGIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_BITS-1:0] pixel_x = '0;
	logic [COORD_BITS-1:0] pixel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SHADE_W-1:0] shade;

	bit hold_req = 1'b0;
	bit calm = 1'b0;
	int quiet_left = 0;

	shade_scoreboard sb = new();

	tricorn_escape_time_pixel_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.shade(shade)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_shade(shade);
	end

	task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
		int gap;
		in_valid <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_pixel(px, py);
		gap = 0;
		if (!calm) begin
			if (quiet_left > 0)
				quiet_left--;
			else if ($urandom_range(0, 19) == 0)
				quiet_left = $urandom_range(20, 60);
			else if ($urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 17);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender waits here until every shade has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic load_view(input logic [CFG_DATA_W-1:0] xo, input logic [CFG_DATA_W-1:0] yo,
			input logic [CFG_DATA_W-1:0] xs, input logic [CFG_DATA_W-1:0] ys,
			input logic [CFG_DATA_W-1:0] spc);
		cfg_idx_t regs[5];
		logic [CFG_DATA_W-1:0] vals[5];
		regs = '{CFG_X_ORIGIN, CFG_Y_ORIGIN, CFG_X_STEP, CFG_Y_STEP, CFG_STEPS_PER_CHECK};
		vals = '{xo, yo, xs, ys, spc};
		foreach (regs[i]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic pixel_run(input int n);
		repeat (n) send_pixel(COORD_BITS'($urandom_range(0, PIX_MAX)),
			COORD_BITS'($urandom_range(0, PIX_MAX)));
		drain();
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 9) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: corners, centre, first-test boundary, fixed point on the real axis
		send_pixel(0, 0);
		send_pixel(COORD_BITS'(PIX_MAX), COORD_BITS'(PIX_MAX));
		send_pixel(0, COORD_BITS'(PIX_MAX));
		send_pixel(COORD_BITS'(PIX_MAX), 0);
		send_pixel(350, 350);
		send_pixel(350, 0);
		send_pixel(0, 350);
		send_pixel(175, 350);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'h155, 10'h2AA);
		drain();

		// no updates between tests
		load_view(X_ORIGIN_RST, Y_ORIGIN_RST, CFG_DATA_W'(X_STEP_RST), CFG_DATA_W'(Y_STEP_RST),
			32'hFFFF_FFF0);
		send_pixel(350, 350);
		send_pixel(0, 0);
		drain();

		// mapping saturates at both ends
		load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2);
		send_pixel(COORD_BITS'(PIX_MAX), COORD_BITS'(PIX_MAX));
		send_pixel(0, 0);
		send_pixel(1, 1);
		drain();

		// c exactly 2, passes the first test on the boundary
		load_view(32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'd1);
		send_pixel(5, 9);
		drain();

		// c = 0 at the deepest update count
		load_view(32'h0, 32'h0, 32'h0, 32'h0, 32'd15);
		send_pixel(COORD_BITS'(PIX_MAX), 0);
		drain();

		load_view(X_ORIGIN_RST, Y_ORIGIN_RST, {1'b1, X_STEP_RST}, {1'b1, Y_STEP_RST}, 32'd1);
		hold_req = 1'b1;
		pixel_run(300);

		load_view(X_ORIGIN_RST, Y_ORIGIN_RST, CFG_DATA_W'(X_STEP_RST), CFG_DATA_W'(Y_STEP_RST),
			32'hFFFF_FFF0);
		pixel_run(80);

		repeat (4) begin
			load_view($urandom, $urandom, $urandom, $urandom, $urandom | 32'hF);
			pixel_run(25);
		end

		// zoomed onto the set, a few updates per test
		repeat (5) begin
			load_view(32'hEC00_0000, 32'hEC00_0000, 32'd655360, 32'd655360,
				$urandom_range(2, 6));
			pixel_run(30);
		end

		load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3);
		pixel_run(80);

		repeat (8) begin
			load_view($urandom, $urandom, $urandom, $urandom, $urandom);
			pixel_run(25);
		end

		calm = 1'b1;
		load_view(X_ORIGIN_RST, Y_ORIGIN_RST, CFG_DATA_W'(X_STEP_RST), CFG_DATA_W'(Y_STEP_RST),
			CFG_DATA_W'(SPC_RST));
		pixel_run(140);

		repeat (600) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tetp_pkg.sv
sv/tetp_front.sv
sv/tetp_queue.sv
sv/tetp_core.sv
sv/tricorn_escape_time_pixel_top.sv
tb/tricorn_escape_time_pixel_top_tb.sv
